/* rtl/core/lpfp_pkg.sv */
// Shared codes and result record for the length-prefixed frame parser.
package lpfp_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERSION  = 2'd1;
  localparam logic [1:0] ERR_LENGTH   = 2'd2;

  localparam logic CFG_EXPECTED_VERSION = 1'b0;
  localparam logic CFG_MAX_PAYLOAD      = 1'b1;

  localparam logic [7:0]  VERSION_RESET     = 8'd1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

/* rtl/core/length_prefixed_frame_parser_unit.sv */
// Top level of the length-prefixed frame parser.
//
// Usage: one received byte enters per item on the input channel (in_valid,
// in_stall, rx_byte). Frames are a version byte, a type byte and a big-endian
// 16-bit length, then the payload. Each payload byte leaves as one result item
// tagged with type and length, last set on the final byte. A zero-length frame
// gives one empty-frame item; a bad version or oversize length gives one error
// item, after which all bytes are dropped until reset.
// An accepted byte is held in the input register; its result (if any) goes to
// the output register once the output can take it. Throughput is one byte per
// cycle while out_stall does not hold the output, set by the single decode
// step between the input and output registers. Configuration (cfg_write,
// cfg_index, cfg_data) is for the user to write while idle; the block does
// not enforce it. Index 0 is the expected version, index 1 the maximum payload
// length. Reset (rst, synchronous) empties both registers, restores the
// register defaults (version 1, maximum 1024) and returns the parser to the
// header. When out_stall holds a result, an empty input register still takes
// one item; once it holds an item waiting for the output, in_stall is raised.
module length_prefixed_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  error_code,
  output logic [7:0]  frame_type,
  output logic [15:0] frame_length,
  output logic [7:0]  payload_byte,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic              in_held;
  logic [7:0]        byte_q;
  logic [7:0]        expected_version;
  logic [15:0]       max_payload;
  logic              out_ready;
  logic              step;
  lpfp_pkg::result_t result;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = in_held && !out_ready;
  assign step      = in_held && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= lpfp_pkg::VERSION_RESET;
      max_payload      <= lpfp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lpfp_pkg::CFG_EXPECTED_VERSION: expected_version <= cfg_data[7:0];
        lpfp_pkg::CFG_MAX_PAYLOAD:      max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (!in_stall) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_q <= rx_byte;
    end
  end

  lpfp_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .rx_byte          (byte_q),
    .expected_version (expected_version),
    .max_payload      (max_payload),
    .result           (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      kind         <= result.kind;
      error_code   <= result.error_code;
      frame_type   <= result.frame_type;
      frame_length <= result.frame_length;
      payload_byte <= result.payload_byte;
      last         <= result.last;
    end
  end

endmodule

/* rtl/core/lpfp_parser.sv */
// Frame parser state and the per-byte result decode.
module lpfp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          expected_version,
  input  logic [15:0]         max_payload,
  output lpfp_pkg::result_t   result
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  localparam logic [lpfp_pkg::HDR_IDX_W-1:0] HDR_LAST =
    lpfp_pkg::HDR_IDX_W'(lpfp_pkg::HEADER_BYTES - 1);

  phase_t                          phase, phase_next;
  logic [lpfp_pkg::HDR_IDX_W-1:0]  header_index, header_index_next;
  logic [7:0]                      version_seen, version_seen_next;
  logic [7:0]                      type_seen, type_seen_next;
  logic [7:0]                      length_high, length_high_next;
  logic [15:0]                     payload_length, payload_length_next;
  logic [15:0]                     bytes_left, bytes_left_next;
  logic [15:0]                     hdr_length;

  assign hdr_length = {length_high, rx_byte};

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    version_seen_next   = version_seen;
    type_seen_next      = type_seen;
    length_high_next    = length_high;
    payload_length_next = payload_length;
    bytes_left_next     = bytes_left;
    result              = '0;
    result.frame_type   = type_seen;
    result.frame_length = payload_length;

    case (phase)
      PH_HEADER: begin
        if (header_index == HDR_LAST) begin
          payload_length_next = hdr_length;
          header_index_next   = '0;
          result.valid        = 1'b1;
          result.frame_length = hdr_length;
          if (version_seen != expected_version) begin
            phase_next        = PH_DROP;
            result.kind       = lpfp_pkg::KIND_ERROR;
            result.error_code = lpfp_pkg::ERR_VERSION;
          end else if (hdr_length > max_payload) begin
            phase_next        = PH_DROP;
            result.kind       = lpfp_pkg::KIND_ERROR;
            result.error_code = lpfp_pkg::ERR_LENGTH;
          end else if (hdr_length == 16'd0) begin
            result.kind       = lpfp_pkg::KIND_EMPTY;
            result.last       = 1'b1;
          end else begin
            result.valid      = 1'b0;
            bytes_left_next   = hdr_length;
            phase_next        = PH_PAYLOAD;
          end
        end else begin
          header_index_next = header_index + 1'b1;
          case (header_index)
            2'd0:    version_seen_next = rx_byte;
            2'd1:    type_seen_next    = rx_byte;
            default: length_high_next  = rx_byte;
          endcase
        end
      end
      PH_PAYLOAD: begin
        result.valid        = 1'b1;
        result.kind         = lpfp_pkg::KIND_PAYLOAD;
        result.payload_byte = rx_byte;
        result.last         = (bytes_left <= 16'd1);
        if (bytes_left <= 16'd1) begin
          bytes_left_next = '0;
          phase_next      = PH_HEADER;
        end else begin
          bytes_left_next = bytes_left - 16'd1;
        end
      end
      default: begin
        // drop everything until reset
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_index   <= '0;
      version_seen   <= '0;
      type_seen      <= '0;
      length_high    <= '0;
      payload_length <= '0;
      bytes_left     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      version_seen   <= version_seen_next;
      type_seen      <= type_seen_next;
      length_high    <= length_high_next;
      payload_length <= payload_length_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

/* tb/deframer_monitor.sv */
// Watches the frame parser channels, predicts each result item and compares it.
module deframer_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [1:0]  error_code,
  input  logic [7:0]  frame_type,
  input  logic [15:0] frame_length,
  input  logic [7:0]  payload_byte,
  input  logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          failures,
  output int          pending
);

  typedef enum logic [1:0] {
    PARSE_HEADER,
    PARSE_PAYLOAD,
    PARSE_DROP
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        last;
  } frame_item_t;

  logic [7:0]   want_version;
  logic [15:0]  length_cap;
  parse_phase_t phase;
  logic [1:0]   hdr_count;
  logic [7:0]   hdr_version;
  logic [7:0]   hdr_type;
  logic [7:0]   hdr_len_hi;
  logic [15:0]  cur_length;
  logic [15:0]  remaining;
  frame_item_t  expected_items[$];
  int           mismatches = 0;

  task automatic push_item(input logic [1:0] k, input logic [1:0] err,
                           input logic [7:0] data, input logic fin);
    frame_item_t item;
    item.kind         = k;
    item.error_code   = err;
    item.frame_type   = hdr_type;
    item.frame_length = cur_length;
    item.payload_byte = data;
    item.last         = fin;
    expected_items.push_back(item);
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic fin;
    case (phase)
      PARSE_HEADER: begin
        if (hdr_count != 2'd3) begin
          if (hdr_count == 2'd0) hdr_version = b;
          else if (hdr_count == 2'd1) hdr_type = b;
          else hdr_len_hi = b;
          hdr_count = hdr_count + 2'd1;
        end else begin
          cur_length = {hdr_len_hi, b};
          hdr_count  = 2'd0;
          // a bad version wins over an oversize length
          if (hdr_version != want_version) begin
            phase = PARSE_DROP;
            push_item(lpfp_pkg::KIND_ERROR, lpfp_pkg::ERR_VERSION, 8'h00, 1'b0);
          end else if (cur_length > length_cap) begin
            phase = PARSE_DROP;
            push_item(lpfp_pkg::KIND_ERROR, lpfp_pkg::ERR_LENGTH, 8'h00, 1'b0);
          end else if (cur_length == 16'd0) begin
            push_item(lpfp_pkg::KIND_EMPTY, lpfp_pkg::ERR_NONE, 8'h00, 1'b1);
          end else begin
            remaining = cur_length;
            phase     = PARSE_PAYLOAD;
          end
        end
      end
      PARSE_PAYLOAD: begin
        fin = (remaining <= 16'd1);
        push_item(lpfp_pkg::KIND_PAYLOAD, lpfp_pkg::ERR_NONE, b, fin);
        if (fin) begin
          remaining = 16'd0;
          phase     = PARSE_HEADER;
        end else begin
          remaining = remaining - 16'd1;
        end
      end
      default: ;  // drop everything until reset
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    frame_item_t oldest;
    if (rst) begin
      want_version = lpfp_pkg::VERSION_RESET;
      length_cap   = lpfp_pkg::MAX_PAYLOAD_RESET;
      phase        = PARSE_HEADER;
      hdr_count    = 2'd0;
      hdr_version  = 8'h00;
      hdr_type     = 8'h00;
      hdr_len_hi   = 8'h00;
      cur_length   = 16'd0;
      remaining    = 16'd0;
      expected_items.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == lpfp_pkg::CFG_EXPECTED_VERSION) want_version = cfg_data[7:0];
        else length_cap = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          $display("%0t: unexpected result item kind %0d type %0d length %0d byte %0d",
                   $time, kind, frame_type, frame_length, payload_byte);
          mismatches++;
        end else begin
          oldest = expected_items.pop_front();
          check_field("kind", 16'(oldest.kind), 16'(kind));
          check_field("error_code", 16'(oldest.error_code), 16'(error_code));
          check_field("frame_type", 16'(oldest.frame_type), 16'(frame_type));
          check_field("frame_length", oldest.frame_length, frame_length);
          check_field("payload_byte", 16'(oldest.payload_byte), 16'(payload_byte));
          check_field("last", 16'(oldest.last), 16'(last));
        end
      end
      if (in_valid && !in_stall) parse_rx_byte(rx_byte);
    end
    failures <= mismatches;
    pending  <= expected_items.size();
  end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the length-prefixed frame parser.
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;
  logic [7:0]  payload_byte;
  logic        last;
  int          failures;
  int          pending;
  bit          idle_on = 1'b1;
  int          sent = 0;

  length_prefixed_frame_parser_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .error_code(error_code), .frame_type(frame_type),
    .frame_length(frame_length), .payload_byte(payload_byte), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  deframer_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .error_code(error_code), .frame_type(frame_type),
    .frame_length(frame_length), .payload_byte(payload_byte), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("length_prefixed_frame_parser_unit verification failed");
    $finish;
  end

  // in_valid is left high after acceptance so back-to-back items never toggle it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(15, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_header(input logic [7:0] ver, input logic [7:0] ftype,
                             input logic [15:0] len);
    send_byte(ver);
    send_byte(ftype);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] ftype,
                            input logic [15:0] len, input int fill);
    send_header(ver, ftype, len);
    for (int i = 0; i < len; i++)
      send_byte(fill < 0 ? 8'($urandom_range(255, 0)) : 8'(fill));
  endtask

  // hold until every predicted item is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] ver, input logic [15:0] cap);
    cfg_write <= 1'b1;
    cfg_index <= lpfp_pkg::CFG_EXPECTED_VERSION;
    cfg_data  <= {8'h00, ver};
    @(posedge clk);
    cfg_index <= lpfp_pkg::CFG_MAX_PAYLOAD;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // result side: stall a random number of cycles ahead of each item
  initial begin : result_side
    int n;
    forever begin
      n = idle_on ? $urandom_range(15, 0) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0]  ver;
    logic [7:0]  bad_ver;
    logic [15:0] cap;
    logic [15:0] len;
    int          span;
    int          frames;
    int          pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults first, then boundary settings
    send_frame(8'd1, 8'h00, 16'd0, 0);
    send_frame(8'd1, 8'hFF, 16'd1, 8'h00);
    send_frame(8'd1, 8'h5A, 16'd2, 8'hFF);
    drain();
    write_cfg(8'hFF, 16'd3);
    send_frame(8'hFF, 8'hA5, 16'd3, -1);
    drain();
    write_cfg(8'h00, 16'd0);
    send_frame(8'h00, 8'hFF, 16'd0, 0);

    // one frame under the widest length limit, streamed without idling
    drain();
    ver = 8'($urandom_range(255, 0));
    write_cfg(ver, 16'hFFFF);
    idle_on = 1'b0;
    send_frame(ver, 8'($urandom_range(255, 0)), 16'd64, -1);
    idle_on = 1'b1;

    while (sent < 800) begin
      drain();
      ver = 8'($urandom_range(255, 0));
      case ($urandom_range(3, 0))
        0: cap = 16'd0;
        1: cap = 16'($urandom_range(8, 1));
        2: cap = 16'($urandom_range(300, 9));
        default: cap = 16'hFFFF;
      endcase
      write_cfg(ver, cap);
      idle_on = ($urandom_range(3, 0) != 0);
      frames = $urandom_range(12, 3);
      span = (cap < 24) ? int'(cap) : 24;
      repeat (frames) begin
        if (sent < 800) begin
          case ($urandom_range(9, 0))
            0: len = 16'd0;
            1: len = (cap < 64) ? cap : 16'd64;
            default: len = 16'($urandom_range(span, 0));
          endcase
          send_frame(ver, 8'($urandom_range(255, 0)), len, -1);
        end
      end
    end
    idle_on = 1'b1;

    // header errors are sticky until reset, so exactly one comes last
    drain();
    pick = $urandom_range(2, 0);
    ver = 8'($urandom_range(255, 0));
    bad_ver = ver ^ 8'($urandom_range(255, 1));
    if (pick == 0) begin
      cap = 16'($urandom_range(65535, 0));
      len = 16'($urandom_range(cap, 0));
    end else begin
      cap = 16'($urandom_range(65534, 0));
      len = 16'($urandom_range(65535, cap + 1));
    end
    write_cfg(ver, cap);
    send_header((pick == 1) ? ver : bad_ver, 8'($urandom_range(255, 0)), len);
    // everything after the error must be dropped, header-like bytes included
    repeat ($urandom_range(40, 10)) send_byte(8'($urandom_range(255, 0)));
    drain();
    repeat (6) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("length_prefixed_frame_parser_unit verification clean");
    end else begin
      $display("length_prefixed_frame_parser_unit verification failed");
    end
    $finish;
  end

endmodule
